// ===== sv/ttc_pkg.sv =====
`timescale 1ns / 1ps
package ttc_pkg;

  localparam int unsigned ChainSecLen = 64;
  localparam int unsigned ChainUsLen  = 20;
  localparam logic [31:0] TbReset     = 32'd10000000;
  localparam logic [19:0] UsPerSec    = 20'd1000000;
  localparam logic        OpSplit     = 1'b0;
  localparam logic        OpJoin      = 1'b1;

  // one item moving along a divider chain
  typedef struct packed {
    logic        op;
    logic        tbz;
    logic [31:0] rem;
    logic [31:0] div;
    logic [63:0] num;
    logic [63:0] aux;
  } ttc_item_t;

endpackage

// ===== sv/ttc_div_cell.sv =====
`timescale 1ns / 1ps
module ttc_div_cell
  import ttc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      vld_in,
  input  ttc_item_t item_in,
  output logic      vld_out,
  output ttc_item_t item_out
);

  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;
  ttc_item_t   item_next;

  // one restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    sh        = {item_in.rem, item_in.num[63]};
    diff      = sh - {1'b0, item_in.div};
    ge        = (sh >= {1'b0, item_in.div});
    item_next = item_in;
    item_next.rem = ge ? diff[31:0] : sh[31:0];
    item_next.num = {item_in.num[62:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out <= item_next;
    end
  end

endmodule

// ===== sv/tick_time_converter_top.sv =====
`timescale 1ns / 1ps
// tick / time converter
//
// input channel: in_valid, in_stall and the fields op, tick_count, seconds_in,
// micros_in. a transaction completes on a clock edge with in_valid high and
// in_stall low. op 0 splits tick_count into seconds_out and micros_out using
// the timebase; op 1 joins seconds_in and micros_in into ticks_out.
// output channel: out_valid, out_stall and the three result fields; every
// input transaction yields exactly one output transaction, in order.
// config channel: cfg_valid, cfg_ready (always high), cfg_data sets the
// timebase in ticks per second; write it only while the block is idle.
//
// throughput one transaction per cycle while the receiver does not stall. the
// pipe is built from two chains of divider cells, 64 cells for the quotient
// of the tick count and 20 cells for the microsecond quotient, each cell
// settling one quotient bit.
// when the receiver stalls with a result waiting, the whole pipe holds and
// in_stall rises in the same cycle. synchronous reset empties the pipe and
// restores the timebase to 10 MHz.
module tick_time_converter_top
  import ttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [63:0] tick_count,
  input  logic [63:0] seconds_in,
  input  logic [19:0] micros_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] seconds_out,
  output logic [19:0] micros_out,
  output logic [63:0] ticks_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0] timebase;
  logic        adv;

  // front stage: partial products
  logic        s0_v;
  logic        s0_op;
  logic        s0_tbz;
  logic [31:0] s0_tb;
  logic [63:0] s0_p0;
  logic [31:0] s0_p1;
  logic [51:0] s0_p2;
  logic [63:0] s0_tick;
  logic [31:0] p1_full;

  // chain entry and the two chains
  logic      c1_v [0:ChainSecLen];
  ttc_item_t c1   [0:ChainSecLen];
  logic      c2_v [0:ChainUsLen];
  ttc_item_t c2   [0:ChainUsLen];

  // middle stage: remainder scaled to microseconds
  logic        s2_v;
  ttc_item_t   s2;
  ttc_item_t   s2_next;
  logic [51:0] s2_m;
  ttc_item_t   c2_next;

  // whole pipe moves unless a finished result is held by the receiver
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timebase <= TbReset;
    end else if (cfg_valid && cfg_ready) begin
      timebase <= cfg_data;
    end
  end

  // only the low half of the upper partial product survives the wrap
  assign p1_full = 32'(seconds_in[63:32] * timebase);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op   <= op;
      s0_tbz  <= (timebase == 32'd0);
      s0_tb   <= timebase;
      s0_p0   <= seconds_in[31:0] * timebase;
      s0_p1   <= p1_full;
      s0_p2   <= micros_in * timebase;
      s0_tick <= tick_count;
    end
  end

  // op 0 divides ticks by the timebase, op 1 divides micros*tb by one million
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v[0] <= 1'b0;
    end else if (adv) begin
      c1_v[0] <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1[0].op  <= s0_op;
      c1[0].tbz <= s0_tbz;
      c1[0].rem <= 32'd0;
      if (s0_op == OpJoin) begin
        c1[0].div <= {12'd0, UsPerSec};
        c1[0].num <= {12'd0, s0_p2};
        c1[0].aux <= s0_p0 + {s0_p1, 32'd0};
      end else begin
        c1[0].div <= s0_tb;
        c1[0].num <= s0_tick;
        c1[0].aux <= 64'd0;
      end
    end
  end

  for (genvar i = 0; i < ChainSecLen; i++) begin : g_sec
    ttc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .vld_in   (c1_v[i]),
      .item_in  (c1[i]),
      .vld_out  (c1_v[i+1]),
      .item_out (c1[i+1])
    );
  end

  // seconds (op 0) or the final tick sum (op 1) settles here
  always_comb begin
    s2_next = c1[ChainSecLen];
    if (c1[ChainSecLen].op == OpJoin) begin
      s2_next.aux = c1[ChainSecLen].aux + c1[ChainSecLen].num;
    end else begin
      s2_next.aux = c1[ChainSecLen].num;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= c1_v[ChainSecLen];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2   <= s2_next;
      s2_m <= c1[ChainSecLen].rem * UsPerSec;
    end
  end

  // microsecond quotient is below 2^20, so the top bits start as remainder
  always_comb begin
    c2_next     = s2;
    c2_next.rem = s2_m[51:20];
    c2_next.num = {s2_m[19:0], 44'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_v[0] <= 1'b0;
    end else if (adv) begin
      c2_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2[0] <= c2_next;
    end
  end

  for (genvar j = 0; j < ChainUsLen; j++) begin : g_us
    ttc_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .vld_in   (c2_v[j]),
      .item_in  (c2[j]),
      .vld_out  (c2_v[j+1]),
      .item_out (c2[j+1])
    );
  end

  // output register, doubles as the hold stage while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c2_v[ChainUsLen];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c2[ChainUsLen].op == OpJoin) begin
        seconds_out <= 64'd0;
        micros_out  <= 20'd0;
        ticks_out   <= c2[ChainUsLen].aux;
      end else if (c2[ChainUsLen].tbz) begin
        // zero timebase: divider answers all ones, no remainder
        seconds_out <= '1;
        micros_out  <= 20'd0;
        ticks_out   <= 64'd0;
      end else begin
        seconds_out <= c2[ChainUsLen].aux;
        micros_out  <= c2[ChainUsLen].num[19:0];
        ticks_out   <= 64'd0;
      end
    end
  end

endmodule

// ===== sv/ttc_checker.sv =====
`timescale 1ns / 1ps
module ttc_checker
  import ttc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] seconds_out,
  input logic [19:0] micros_out,
  input logic [63:0] ticks_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ticks_out == 64'd0 || (seconds_out == 64'd0 && micros_out == 20'd0)))
    else $error("both conversion directions nonzero");

  a_us_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (micros_out < UsPerSec))
    else $error("microseconds out of range");

endmodule

bind tick_time_converter_top ttc_checker u_ttc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .seconds_out (seconds_out),
  .micros_out  (micros_out),
  .ticks_out   (ticks_out)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ttc_pkg::*;

  typedef struct {
    logic [63:0] secs;
    logic [19:0] us;
    logic [63:0] ticks;
  } conv_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OpSplit;
  logic [63:0] tick_count = '0;
  logic [63:0] seconds_in = '0;
  logic [19:0] micros_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] seconds_out;
  logic [19:0] micros_out;
  logic [63:0] ticks_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // predictor copy of the timebase register
  logic [31:0] model_tb_hz;
  conv_res_t   pending_conv[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          no_gaps = 1'b0;
  bit          hold_rx = 1'b0;

  localparam int WatchLimit = 20000;

  tick_time_converter_top u_top (.*);

  always #5 clk = ~clk;

  // conversion predictor at the block widths
  function automatic conv_res_t convert(logic o, logic [63:0] tk, logic [63:0] s,
                                        logic [19:0] u, logic [31:0] hz);
    conv_res_t r;
    logic [63:0] rem;
    r.secs = '0;
    r.us = '0;
    r.ticks = '0;
    if (o == OpSplit) begin
      if (hz == 0) begin
        // divide by zero gives all ones, no remainder
        r.secs = '1;
      end else begin
        r.secs = tk / {32'd0, hz};
        rem = tk % {32'd0, hz};
        r.us = 20'((rem * 64'd1000000) / {32'd0, hz});
      end
    end else begin
      r.ticks = s * {32'd0, hz} + ({44'd0, u} * {32'd0, hz}) / 64'd1000000;
    end
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    conv_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_conv.size() == 0) begin
        $display("mismatch: unexpected output transaction");
        err_count++;
      end else begin
        e = pending_conv.pop_front();
        if (seconds_out !== e.secs) report("seconds_out", seconds_out, e.secs);
        if (micros_out !== e.us) report("micros_out", {44'd0, micros_out}, {44'd0, e.us});
        if (ticks_out !== e.ticks) report("ticks_out", ticks_out, e.ticks);
      end
    end
  end

  // receiver stalls, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_rx) out_stall <= 1'b1;
    else if (no_gaps) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 20);
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one input transaction, with an optional random gap first
  task automatic send_item(logic o, logic [63:0] tk, logic [63:0] s, logic [19:0] u);
    while (!no_gaps && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    tick_count <= tk;
    seconds_in <= s;
    micros_in <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_conv.push_back(convert(o, tk, s, u, model_tb_hz));
  endtask

  task automatic drain();
    int n;
    n = 0;
    // drop valid right at the accepting edge so the last item is not taken twice
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_conv.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic set_timebase(logic [31:0] hz);
    cfg_valid <= 1'b1;
    cfg_data <= hz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_tb_hz = hz;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // edges of both operations, zero timebase included
  task automatic test_directed();
    send_item(OpSplit, 64'd0, '0, '0);
    send_item(OpSplit, '1, '0, '0);
    send_item(OpSplit, 64'd9999999, '0, '0);
    send_item(OpSplit, 64'd10000000, '0, '0);
    send_item(OpJoin, '0, '0, '0);
    send_item(OpJoin, '0, '1, 20'd999999);
    // microseconds above one second used as given
    send_item(OpJoin, '0, 64'd5, '1);
    send_item(OpJoin, '1, 64'h1234_5678_9abc_def0, 20'd500000);
    drain();
    set_timebase(32'd0);
    send_item(OpSplit, 64'd12345, '0, '0);
    send_item(OpSplit, '1, '0, '0);
    send_item(OpJoin, '0, '1, '1);
    drain();
    set_timebase('1);
    send_item(OpSplit, '1, '0, '0);
    send_item(OpSplit, 64'hFFFF_FFFE, '0, '0);
    send_item(OpJoin, '0, '1, 20'd999999);
    send_item(OpJoin, '0, 64'hFFFF_FFFF, '1);
    drain();
    set_timebase(32'd1);
    send_item(OpSplit, '1, '0, '0);
    send_item(OpJoin, '0, '1, 20'd999999);
    drain();
  endtask

  // random items across several timebases
  task automatic test_random(int count);
    logic [63:0] s;
    logic [19:0] u;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        drain();
        case ($urandom_range(3))
          0: set_timebase($urandom_range(1000, 1));
          1: set_timebase($urandom());
          2: set_timebase(32'd1000000);
          default: set_timebase(32'hFFFF_FFFF - $urandom_range(10));
        endcase
      end
      // mostly valid microseconds, some above range
      u = ($urandom_range(9) == 0) ? 20'($urandom()) : 20'($urandom_range(999999));
      s = ($urandom_range(1)) ? rand64() : 64'($urandom_range(100000));
      send_item(1'($urandom()), rand64() >> $urandom_range(63), s, u);
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 150; i++) send_item(1'($urandom()), rand64(), rand64(),
                                              20'($urandom_range(999999)));
    join
    drain();
  endtask

  // back-to-back traffic with no idling
  task automatic test_streaming();
    no_gaps = 1'b1;
    test_random(150);
    no_gaps = 1'b0;
  endtask

  initial begin
    model_tb_hz = TbReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_backpressure();
    test_streaming();
    if (err_count == 0 && pending_conv.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
